// ----- rtl/core/vlpm_pkg.sv -----
// shared types and constants for the video layer priority mixer
package vlpm_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_LAYER_ORDER     = 3'd0;
  localparam logic [2:0] REG_MIX_MODE        = 3'd1;
  localparam logic [2:0] REG_STENCIL_ENABLE  = 3'd2;
  localparam logic [2:0] REG_KEY_COLOUR      = 3'd3;
  localparam logic [2:0] REG_FALLBACK_COLOUR = 3'd4;

  // layer orders: S sprite, L bitmap, U screen/tilemap, first on top
  localparam logic [2:0] ORDER_SLU       = 3'd0;
  localparam logic [2:0] ORDER_LSU       = 3'd1;
  localparam logic [2:0] ORDER_SUL       = 3'd2;
  localparam logic [2:0] ORDER_LUS       = 3'd3;
  localparam logic [2:0] ORDER_USL       = 3'd4;
  localparam logic [2:0] ORDER_ULS       = 3'd5;
  localparam logic [2:0] ORDER_BLEND_ADD = 3'd6;
  localparam logic [2:0] ORDER_BLEND_SUB = 3'd7;

  // blend mix source
  localparam logic [1:0] MIX_SCREEN   = 2'd0;
  localparam logic [1:0] MIX_NONE     = 2'd1;
  localparam logic [1:0] MIX_COMBINED = 2'd2;
  localparam logic [1:0] MIX_TILEMAP  = 2'd3;

  // reset values
  localparam logic [7:0]  KEY_COLOUR_RST      = 8'hE3;
  localparam logic [15:0] FALLBACK_COLOUR_RST = 16'h0000;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  layer_order;
    logic [1:0]  mix_mode;
    logic        stencil_enable;
    logic [7:0]  key_colour;
    logic [15:0] fallback_colour;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  c8;
    logic [8:0]  c9;
    logic [15:0] c16;
  } colour_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic        bm_pri;
    logic        bm_tr;
    logic [15:0] bm_c16;
    logic [8:0]  bm_c9;
    logic        spr_op;
    logic [15:0] spr_c;
    logic        uf_tr;
    logic [15:0] uf_c16;
    logic        u_shown;
    logic [8:0]  mix_c9;
    logic        mix_tr;
    logic        top_tr;
    logic [15:0] top_c16;
    logic        bot_tr;
    logic [15:0] bot_c16;
  } pix_class_t;

endpackage

// ----- rtl/core/vlpm_front.sv -----
// front end: transparency, screen/tilemap combine and blend source selection
module vlpm_front (
  input  vlpm_pkg::cfg_t       cfg,
  input  logic [2:0]           screen_flags,
  input  logic [32:0]          screen_colour,
  input  logic [3:0]           tile_flags,
  input  logic [32:0]          tile_colour,
  input  logic                 sprite_valid,
  input  logic [15:0]          sprite_colour,
  input  logic                 bitmap_valid,
  input  logic                 bitmap_priority,
  input  logic [32:0]          bitmap_colour,
  output vlpm_pkg::pix_class_t cls
);

  vlpm_pkg::colour_t scr_raw, tm_raw, bm_raw;
  vlpm_pkg::colour_t smix, scr, tm, st, ut, uf, mix, top, bot;
  logic s_en, s_border, s_clip, t_en, t_pix, t_below, t_text;
  logic smix_tr, s_tr, t_tr, st_tr, ut_tr, uf_tr, bm_tr, mix_tr, top_tr, bot_tr;

  // unpack the three colour forms
  assign scr_raw = vlpm_pkg::colour_t'({screen_colour[32:25], screen_colour[24:16],
                                        screen_colour[15:0]});
  assign tm_raw  = vlpm_pkg::colour_t'({tile_colour[32:25], tile_colour[24:16],
                                        tile_colour[15:0]});
  assign bm_raw  = vlpm_pkg::colour_t'({bitmap_colour[32:25], bitmap_colour[24:16],
                                        bitmap_colour[15:0]});

  assign s_en     = screen_flags[0];
  assign s_border = screen_flags[1];
  assign s_clip   = screen_flags[2];
  assign t_en     = tile_flags[0];
  assign t_pix    = tile_flags[1];
  assign t_below  = tile_flags[2];
  assign t_text   = tile_flags[3];

  // layer transparency and black-out
  assign smix_tr = s_clip || (scr_raw.c8 == cfg.key_colour);
  assign smix    = smix_tr ? '0 : scr_raw;
  assign s_tr    = smix_tr || !s_en;
  assign scr     = s_tr ? '0 : scr_raw;
  assign t_tr    = !t_en || !t_pix || (t_text && (tm_raw.c8 == cfg.key_colour));
  assign tm      = t_tr ? '0 : tm_raw;
  assign bm_tr   = !bitmap_valid || (bm_raw.c8 == cfg.key_colour);

  // stencil and below-priority combine
  assign st_tr = s_tr || t_tr;
  assign st    = st_tr ? '0 : (scr & tm);
  assign ut_tr = s_tr && t_tr;
  assign ut    = (!t_tr && (!t_below || s_tr)) ? tm : scr;

  always_comb begin
    if (cfg.stencil_enable && s_en && t_en) begin
      uf    = st;
      uf_tr = st_tr;
    end else begin
      uf    = ut;
      uf_tr = ut_tr;
    end
  end

  // blend mix colour and the layers around the sprite in blend orders
  always_comb begin
    mix    = '0;
    mix_tr = 1'b1;
    top    = tm;
    top_tr = 1'b1;
    bot    = tm;
    bot_tr = 1'b1;
    unique case (cfg.mix_mode)
      vlpm_pkg::MIX_SCREEN: begin
        mix    = smix;
        mix_tr = smix_tr;
        top_tr = t_tr || t_below;
        bot_tr = t_tr || !t_below;
      end
      vlpm_pkg::MIX_COMBINED: begin
        mix    = uf;
        mix_tr = uf_tr;
      end
      vlpm_pkg::MIX_TILEMAP: begin
        mix    = tm;
        mix_tr = t_tr;
        top    = scr;
        top_tr = s_tr || !t_below;
        bot    = scr;
        bot_tr = s_tr || t_below;
      end
      default: begin
        if (t_below) begin
          top    = scr;
          top_tr = s_tr;
          bot    = tm;
          bot_tr = t_tr;
        end else begin
          top    = tm;
          top_tr = t_tr;
          bot    = scr;
          bot_tr = s_tr;
        end
      end
    endcase
  end

  // pack the classified pixel
  always_comb begin
    cls.bm_pri  = bitmap_priority && !bm_tr;
    cls.bm_tr   = bm_tr;
    cls.bm_c16  = bm_tr ? 16'h0000 : bm_raw.c16;
    cls.bm_c9   = bm_tr ? 9'h000 : bm_raw.c9;
    cls.spr_op  = sprite_valid;
    cls.spr_c   = sprite_valid ? sprite_colour : 16'h0000;
    cls.uf_tr   = uf_tr;
    cls.uf_c16  = uf.c16;
    cls.u_shown = !uf_tr && !(s_border && t_tr && sprite_valid);
    cls.mix_c9  = mix.c9;
    cls.mix_tr  = mix_tr;
    cls.top_tr  = top_tr;
    cls.top_c16 = top.c16;
    cls.bot_tr  = bot_tr;
    cls.bot_c16 = bot.c16;
  end

endmodule

// ----- rtl/core/vlpm_queue.sv -----
// queue of classified pixels between front and back
module vlpm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  vlpm_pkg::pix_class_t push_data,
  output logic                 full,
  input  logic                 pop,
  output vlpm_pkg::pix_class_t pop_data,
  output logic                 empty
);

  vlpm_pkg::pix_class_t mem_r [vlpm_pkg::Q_DEPTH];
  logic [vlpm_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [vlpm_pkg::Q_CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == vlpm_pkg::Q_CNT_W'(vlpm_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");
  // count tracks the pointers
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
      (count_r != vlpm_pkg::Q_CNT_W'(vlpm_pkg::Q_DEPTH)) |->
      (count_r[vlpm_pkg::Q_PTR_W-1:0] == (wr_ptr_r - rd_ptr_r)))
    else $error("fill count disagrees with pointers");

endmodule

// ----- rtl/core/vlpm_back.sv -----
// back end: layer order selection, additive or subtractive blend and result buffer
module vlpm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vlpm_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  vlpm_pkg::pix_class_t q_data,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [15:0]          pixel_colour
);

  vlpm_pkg::pix_class_t c;
  logic [3:0]  r_sum, g_sum, b_sum;
  logic [2:0]  r_bl, g_bl, b_bl;
  logic [15:0] blended, colour;
  logic [15:0] buf_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        out_pop;

  function automatic logic [2:0] sat_add(input logic [3:0] s);
    sat_add = s[3] ? 3'd7 : s[2:0];
  endfunction

  function automatic logic [2:0] minus_five(input logic [3:0] s);
    logic [3:0] d;
    d = s - 4'd5;
    if (s <= 4'd4) begin
      minus_five = 3'd0;
    end else if (s[3:2] == 2'b11) begin
      minus_five = 3'd7;
    end else begin
      minus_five = d[2:0];
    end
  endfunction

  assign c = q_data;

  // per-channel sums of bitmap and mix colour
  assign r_sum = {1'b0, c.bm_c9[8:6]} + {1'b0, c.mix_c9[8:6]};
  assign g_sum = {1'b0, c.bm_c9[5:3]} + {1'b0, c.mix_c9[5:3]};
  assign b_sum = {1'b0, c.bm_c9[2:0]} + {1'b0, c.mix_c9[2:0]};

  always_comb begin
    if (cfg.layer_order == vlpm_pkg::ORDER_BLEND_ADD) begin
      r_bl = sat_add(r_sum);
      g_bl = sat_add(g_sum);
      b_bl = sat_add(b_sum);
    end else if (!c.mix_tr) begin
      r_bl = minus_five(r_sum);
      g_bl = minus_five(g_sum);
      b_bl = minus_five(b_sum);
    end else begin
      r_bl = r_sum[2:0];
      g_bl = g_sum[2:0];
      b_bl = b_sum[2:0];
    end
  end

  assign blended = {r_bl, 1'b0, g_bl, 1'b0, b_bl, 5'b00000};

  // priority pick per layer order
  always_comb begin
    colour = cfg.fallback_colour;
    unique case (cfg.layer_order)
      vlpm_pkg::ORDER_SLU: begin
        if (c.bm_pri) colour = c.bm_c16;
        else if (c.spr_op) colour = c.spr_c;
        else if (!c.bm_tr) colour = c.bm_c16;
        else if (!c.uf_tr) colour = c.uf_c16;
      end
      vlpm_pkg::ORDER_LSU: begin
        if (!c.bm_tr) colour = c.bm_c16;
        else if (c.spr_op) colour = c.spr_c;
        else if (!c.uf_tr) colour = c.uf_c16;
      end
      vlpm_pkg::ORDER_SUL: begin
        if (c.bm_pri) colour = c.bm_c16;
        else if (c.spr_op) colour = c.spr_c;
        else if (!c.uf_tr) colour = c.uf_c16;
        else if (!c.bm_tr) colour = c.bm_c16;
      end
      vlpm_pkg::ORDER_LUS: begin
        if (!c.bm_tr) colour = c.bm_c16;
        else if (c.u_shown) colour = c.uf_c16;
        else if (c.spr_op) colour = c.spr_c;
      end
      vlpm_pkg::ORDER_USL: begin
        if (c.bm_pri) colour = c.bm_c16;
        else if (c.u_shown) colour = c.uf_c16;
        else if (c.spr_op) colour = c.spr_c;
        else if (!c.bm_tr) colour = c.bm_c16;
      end
      vlpm_pkg::ORDER_ULS: begin
        if (c.bm_pri) colour = c.bm_c16;
        else if (c.u_shown) colour = c.uf_c16;
        else if (!c.bm_tr) colour = c.bm_c16;
        else if (c.spr_op) colour = c.spr_c;
      end
      default: begin
        if (c.bm_pri) colour = blended;
        else if (!c.top_tr) colour = c.top_c16;
        else if (c.spr_op) colour = c.spr_c;
        else if (!c.bot_tr) colour = c.bot_c16;
        else if (!c.bm_tr) colour = blended;
      end
    endcase
  end

  // two-entry result buffer, takes a pixel whenever a slot is free or a result is popped at the same edge
  assign out_pop      = pop && !empty;
  assign empty        = (count_r == 2'd0);
  assign q_pop        = !q_empty && ((count_r != 2'd2) || out_pop);
  assign pixel_colour = buf_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (q_pop && !out_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (out_pop && !q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (q_pop) wr_ptr_r <= !wr_ptr_r;
      if (out_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_r[wr_ptr_r] <= colour;
    end
  end

  // buffer never holds more than two results
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("result buffer overfilled");
  // a full buffer with no pop stalls the queue
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
      ((count_r == 2'd2) && !pop) |-> !q_pop)
    else $error("queue read while result buffer full");
  // a waiting classified pixel reaches the buffer next cycle when space exists
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
      (!q_empty && (count_r == 2'd0)) |=> !empty)
    else $error("pixel did not advance to result buffer");

endmodule

// ----- rtl/core/video_layer_priority_mixer_unit.sv -----
// top level of the video layer priority mixer: config registers and front/back wiring
//
// Usage: one pixel's layer flags and colours form an input transaction; it is
// taken at a rising edge with push high and full low. Each input gives exactly
// one result, pixel_colour, shown while empty is low and taken on pop.
// Configuration writes use cfg_valid/cfg_ready (ready is always high) with
// cfg_index 0..4 = layer_order, mix_mode, stencil_enable, key_colour,
// fallback_colour; other indexes are ignored. Write only while idle.
// Path: the front classifies each pixel into a 4-entry queue, and the back end
// picks and blends it into a 2-entry buffer, from which it is shown and popped.
// Throughput: one pixel per cycle sustained while the receiver keeps popping;
// the back end's order/blend logic is a single combinational pass.
// Reset: both queues empty, full low, empty high, registers at reset values
// (key colour 0xE3, others 0).
// When the receiver stalls, the result buffer fills, then the queue, and full
// rises after six pixels are held; nothing is dropped.
module video_layer_priority_mixer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_screen_flags,
  input  logic [32:0] in_screen_colour,
  input  logic [3:0]  in_tile_flags,
  input  logic [32:0] in_tile_colour,
  input  logic        in_sprite_valid,
  input  logic [15:0] in_sprite_colour,
  input  logic        in_bitmap_valid,
  input  logic        in_bitmap_priority,
  input  logic [32:0] in_bitmap_colour,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_pixel_colour,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  vlpm_pkg::cfg_t       cfg_r;
  vlpm_pkg::pix_class_t front_cls, q_data;
  logic                 q_push, q_full, q_pop, q_empty;

  // configuration register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layer_order     <= vlpm_pkg::ORDER_SLU;
      cfg_r.mix_mode        <= vlpm_pkg::MIX_SCREEN;
      cfg_r.stencil_enable  <= 1'b0;
      cfg_r.key_colour      <= vlpm_pkg::KEY_COLOUR_RST;
      cfg_r.fallback_colour <= vlpm_pkg::FALLBACK_COLOUR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vlpm_pkg::REG_LAYER_ORDER:     cfg_r.layer_order     <= cfg_data[2:0];
        vlpm_pkg::REG_MIX_MODE:        cfg_r.mix_mode        <= cfg_data[1:0];
        vlpm_pkg::REG_STENCIL_ENABLE:  cfg_r.stencil_enable  <= cfg_data[0];
        vlpm_pkg::REG_KEY_COLOUR:      cfg_r.key_colour      <= cfg_data[7:0];
        vlpm_pkg::REG_FALLBACK_COLOUR: cfg_r.fallback_colour <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end classifies each accepted pixel
  vlpm_front u_front (
    .cfg             (cfg_r),
    .screen_flags    (in_screen_flags),
    .screen_colour   (in_screen_colour),
    .tile_flags      (in_tile_flags),
    .tile_colour     (in_tile_colour),
    .sprite_valid    (in_sprite_valid),
    .sprite_colour   (in_sprite_colour),
    .bitmap_valid    (in_bitmap_valid),
    .bitmap_priority (in_bitmap_priority),
    .bitmap_colour   (in_bitmap_colour),
    .cls             (front_cls)
  );

  assign full   = q_full;
  assign q_push = push && !q_full;

  vlpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // back end resolves and buffers results
  vlpm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .pixel_colour (out_pixel_colour)
  );

endmodule
